// ----- hdl/btn_pkg.sv -----
// Shared types and constants for the order-4 B-tree node engine.
// Used by every module of the block but the checker; depends on nothing.
package btn_pkg;

    localparam int ORDER    = 4;
    localparam int MAX_KEYS = ORDER - 1;
    localparam int KEY_W    = 32;
    localparam int SLOT_W   = 2;

    // Empty key, record or link.
    localparam logic signed [KEY_W-1:0] NONE       = '1;
    localparam logic signed [2:0]       NONE_SLOT  = '1;

    typedef enum logic [2:0] {
        OP_CLEAR     = 3'd0,
        OP_INSERT    = 3'd1,
        OP_REMOVE    = 3'd2,
        OP_SEARCH    = 3'd3,
        OP_ROUTE     = 3'd4,
        OP_SET_CHILD = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        KIND_LEAF     = 2'd0,
        KIND_ROOT     = 2'd1,
        KIND_INTERNAL = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic [2:0]              op;
        logic signed [KEY_W-1:0] key;
        logic signed [KEY_W-1:0] rec;
        logic signed [KEY_W-1:0] chd;
        logic [SLOT_W-1:0]       slot;
        logic [1:0]              ntype;
    } t_req;

    // Compare results per key slot, collected by the scan.
    typedef struct packed {
        logic [MAX_KEYS-1:0] eq;
        logic [MAX_KEYS-1:0] gt;
    } t_flags;

    typedef struct packed {
        logic              ready;
        logic              commit;
        logic [SLOT_W-1:0] scan_idx;
    } t_seq_ctl;

    typedef struct packed {
        logic                    status;
        logic signed [2:0]       found;
        logic signed [KEY_W-1:0] routed;
        logic                    split;
        logic signed [KEY_W-1:0] pk;
        logic signed [KEY_W-1:0] pr;
        logic signed [KEY_W-1:0] rk;
        logic signed [KEY_W-1:0] rr;
        logic signed [KEY_W-1:0] rc0;
        logic signed [KEY_W-1:0] rc1;
        logic [1:0]              count;
        logic [1:0]              kind;
    } t_res;

endpackage

// ----- hdl/btn_cmp.sv -----
// Shared signed key comparator of the node engine.
// Depends on btn_pkg for the key width.
module btn_cmp (
    input  logic signed [btn_pkg::KEY_W-1:0] i_a,
    input  logic signed [btn_pkg::KEY_W-1:0] i_b,
    output logic                             o_eq,
    output logic                             o_lt
);

    assign o_eq = (i_a == i_b);
    assign o_lt = (i_a < i_b);

endmodule

// ----- hdl/btn_seq.sv -----
// Sequencer: walks the key slots through the shared comparator, one slot
// a cycle, then holds for the commit. Depends on btn_pkg and btn_cmp.
module btn_seq (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_out_free,
    input  logic signed [btn_pkg::KEY_W-1:0] i_probe,
    input  logic signed [btn_pkg::KEY_W-1:0] i_slot_key,
    output btn_pkg::t_seq_ctl                o_ctl,
    output btn_pkg::t_flags                  o_flags
);

    btn_pkg::t_state            r_state, n_state;
    logic [btn_pkg::SLOT_W-1:0] r_idx, n_idx;
    logic [btn_pkg::MAX_KEYS-1:0] r_eq, r_gt;
    logic                       w_eq, w_lt;

    btn_cmp u_cmp (
        .i_a  (i_probe),
        .i_b  (i_slot_key),
        .o_eq (w_eq),
        .o_lt (w_lt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= btn_pkg::ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // A slot key greater than the probe is the same as probe < key.
    always_ff @(posedge i_clk) begin
        if (r_state == btn_pkg::ST_SCAN) begin
            r_eq[r_idx] <= w_eq;
            r_gt[r_idx] <= w_lt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            btn_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = btn_pkg::ST_SCAN;
                    n_idx   = '0;
                end
            end
            btn_pkg::ST_SCAN: begin
                if (r_idx == btn_pkg::SLOT_W'(btn_pkg::MAX_KEYS - 1)) begin
                    n_state = btn_pkg::ST_COMMIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            btn_pkg::ST_COMMIT: begin
                if (i_out_free) begin
                    n_state = btn_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = btn_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_ctl.ready    = (r_state == btn_pkg::ST_IDLE);
    assign o_ctl.commit   = (r_state == btn_pkg::ST_COMMIT) && i_out_free;
    assign o_ctl.scan_idx = r_idx;
    assign o_flags.eq     = r_eq;
    assign o_flags.gt     = r_gt;

endmodule

// ----- hdl/btn_node.sv -----
// Node storage and the update applied at commit: keys, records, links,
// key count and node type. Depends on btn_pkg.
module btn_node (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_commit,
    input  btn_pkg::t_req                    i_req,
    input  btn_pkg::t_flags                  i_flags,
    input  logic [btn_pkg::SLOT_W-1:0]       i_scan_idx,
    output logic signed [btn_pkg::KEY_W-1:0] o_slot_key,
    output btn_pkg::t_res                    o_res
);

    localparam int NK = btn_pkg::MAX_KEYS;
    localparam int NC = btn_pkg::ORDER;

    logic signed [btn_pkg::KEY_W-1:0] r_keys  [NK];
    logic signed [btn_pkg::KEY_W-1:0] r_recs  [NK];
    logic signed [btn_pkg::KEY_W-1:0] r_links [NC];
    logic [1:0]                       r_count;
    btn_pkg::t_kind                   r_kind;

    logic signed [btn_pkg::KEY_W-1:0] n_keys  [NK];
    logic signed [btn_pkg::KEY_W-1:0] n_recs  [NK];
    logic signed [btn_pkg::KEY_W-1:0] n_links [NC];
    logic [1:0]                       n_count;
    btn_pkg::t_kind                   n_kind;

    // Extended copies so that shifted reads stay in range.
    logic signed [btn_pkg::KEY_W-1:0] kx [NK+1];
    logic signed [btn_pkg::KEY_W-1:0] rx [NK+1];
    logic signed [btn_pkg::KEY_W-1:0] cx [NC+1];
    logic signed [btn_pkg::KEY_W-1:0] sk [NK+1];
    logic signed [btn_pkg::KEY_W-1:0] sr [NK+1];
    logic signed [btn_pkg::KEY_W-1:0] sc [NC+1];
    logic signed [btn_pkg::KEY_W-1:0] tk [NK+1];
    logic signed [btn_pkg::KEY_W-1:0] tr [NK+1];
    logic signed [btn_pkg::KEY_W-1:0] tc [NC+1];

    logic [NK-1:0] vm, eqm, gtm;
    logic [1:0]    pos;
    logic [1:0]    ridx;
    btn_pkg::t_res res;

    assign o_slot_key = r_keys[i_scan_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NK; i++) begin
                r_keys[i] <= btn_pkg::NONE;
                r_recs[i] <= btn_pkg::NONE;
            end
            for (int i = 0; i < NC; i++) begin
                r_links[i] <= btn_pkg::NONE;
            end
            r_count <= '0;
            r_kind  <= btn_pkg::KIND_LEAF;
        end else if (i_commit) begin
            r_keys  <= n_keys;
            r_recs  <= n_recs;
            r_links <= n_links;
            r_count <= n_count;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        for (int i = 0; i < NK; i++) begin
            vm[i] = (i < int'(r_count));
        end
        eqm = i_flags.eq & vm;
        gtm = i_flags.gt & vm;

        // Insert position: just above the highest held key not above the probe.
        pos = '0;
        for (int i = 0; i < NK; i++) begin
            if (vm[i] && !gtm[i]) begin
                pos = 2'(i + 1);
            end
        end
        // Route: first held key above the probe, else past the last key.
        ridx = r_count;
        for (int i = NK - 1; i >= 0; i--) begin
            if (gtm[i]) begin
                ridx = 2'(i);
            end
        end

        for (int i = 0; i < NK; i++) begin
            kx[i] = r_keys[i];
            rx[i] = r_recs[i];
        end
        kx[NK] = btn_pkg::NONE;
        rx[NK] = btn_pkg::NONE;
        for (int i = 0; i < NC; i++) begin
            cx[i] = r_links[i];
        end
        cx[NC] = btn_pkg::NONE;

        sk[0] = btn_pkg::NONE;
        sr[0] = btn_pkg::NONE;
        for (int i = 1; i <= NK; i++) begin
            sk[i] = kx[i-1];
            sr[i] = rx[i-1];
        end
        sc[0] = btn_pkg::NONE;
        for (int i = 1; i <= NC; i++) begin
            sc[i] = cx[i-1];
        end

        for (int j = 0; j <= NK; j++) begin
            if (j < int'(pos)) begin
                tk[j] = kx[j];
                tr[j] = rx[j];
            end else if (j == int'(pos)) begin
                tk[j] = i_req.key;
                tr[j] = i_req.rec;
            end else begin
                tk[j] = sk[j];
                tr[j] = sr[j];
            end
        end
        for (int j = 0; j <= NC; j++) begin
            if (j <= int'(pos)) begin
                tc[j] = cx[j];
            end else if (j == int'(pos) + 1) begin
                tc[j] = i_req.chd;
            end else begin
                tc[j] = sc[j];
            end
        end

        n_keys  = r_keys;
        n_recs  = r_recs;
        n_links = r_links;
        n_count = r_count;
        n_kind  = r_kind;

        res        = '0;
        res.found  = btn_pkg::NONE_SLOT;
        res.routed = btn_pkg::NONE;

        case (btn_pkg::t_op'(i_req.op))
            btn_pkg::OP_CLEAR: begin
                for (int i = 0; i < NK; i++) begin
                    n_keys[i] = btn_pkg::NONE;
                    n_recs[i] = btn_pkg::NONE;
                end
                for (int i = 0; i < NC; i++) begin
                    n_links[i] = btn_pkg::NONE;
                end
                n_count = '0;
                // Type code three is taken as a leaf.
                n_kind = (i_req.ntype == 2'd3) ? btn_pkg::KIND_LEAF
                                               : btn_pkg::t_kind'(i_req.ntype);
            end
            btn_pkg::OP_INSERT: begin
                if (int'(r_count) < NK) begin
                    if (|eqm) begin
                        res.status = 1'b1;
                    end else begin
                        for (int j = 0; j < NK; j++) begin
                            if (j <= int'(r_count)) begin
                                n_keys[j] = tk[j];
                                n_recs[j] = tr[j];
                            end
                        end
                        for (int j = 0; j < NC; j++) begin
                            if (j <= int'(r_count) + 1) begin
                                n_links[j] = tc[j];
                            end
                        end
                        n_count = r_count + 2'd1;
                    end
                end else begin
                    // Full node: split without a duplicate check.
                    if (r_kind == btn_pkg::KIND_ROOT) begin
                        n_kind = btn_pkg::KIND_INTERNAL;
                    end
                    n_keys[0]  = tk[0];
                    n_recs[0]  = tr[0];
                    n_keys[1]  = tk[1];
                    n_recs[1]  = tr[1];
                    n_keys[2]  = btn_pkg::NONE;
                    n_recs[2]  = btn_pkg::NONE;
                    n_links[0] = tc[0];
                    n_links[1] = tc[1];
                    n_links[2] = tc[2];
                    n_links[3] = btn_pkg::NONE;
                    n_count    = 2'd2;
                    res.split  = 1'b1;
                    res.pk     = tk[2];
                    res.pr     = tr[2];
                    res.rk     = tk[3];
                    res.rr     = tr[3];
                    res.rc0    = tc[3];
                    res.rc1    = tc[4];
                end
            end
            btn_pkg::OP_REMOVE: begin
                if (i_req.slot >= r_count) begin
                    res.status = 1'b1;
                end else begin
                    for (int j = 0; j < NK; j++) begin
                        if (j >= int'(i_req.slot) && j < int'(r_count) - 1) begin
                            n_keys[j] = kx[j+1];
                            n_recs[j] = rx[j+1];
                        end else if (j == int'(r_count) - 1) begin
                            n_keys[j] = btn_pkg::NONE;
                            n_recs[j] = btn_pkg::NONE;
                        end
                    end
                    for (int j = 0; j < NC; j++) begin
                        if (j >= int'(i_req.slot) + 1 && j < int'(r_count)) begin
                            n_links[j] = cx[j+1];
                        end else if (j == int'(r_count)) begin
                            n_links[j] = btn_pkg::NONE;
                        end
                    end
                    n_count = r_count - 2'd1;
                end
            end
            btn_pkg::OP_SEARCH: begin
                for (int i = NK - 1; i >= 0; i--) begin
                    if (eqm[i]) begin
                        res.found = 3'(i);
                    end
                end
            end
            btn_pkg::OP_ROUTE: begin
                res.routed = r_links[ridx];
            end
            btn_pkg::OP_SET_CHILD: begin
                n_links[0] = i_req.chd;
            end
            default: begin
                res.status = 1'b1;
            end
        endcase

        res.count = n_count;
        res.kind  = n_kind;
    end

    assign o_res = res;

endmodule

// ----- hdl/btree_node_insert_split_engine.sv -----
// Order-4 B-tree node engine. A request is taken at the first edge it is offered
// while idle; its response is registered after three slot compares on the single
// comparator and the commit state, and the next request is taken only after the
// engine has passed back through the idle state. A response still waiting on the
// output holds the commit back and delays both the response and the next request.
// Synchronous active-low reset empties the node (all -1, count 0, leaf).
module btree_node_insert_split_engine (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // tdata: key[31:0], record_ptr[63:32], child_ptr[95:64],
    // slot_index[97:96], new_type[99:98], zero pad [103:100]
    input  logic [103:0] i_s_tdata,
    // tuser: operation[2:0]
    input  logic [2:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // tdata: status[0], found_slot[3:1], routed_child[35:4], did_split[36],
    // promoted_key[68:37], promoted_record[100:69], right_key[132:101],
    // right_record[164:133], right_first_child[196:165],
    // right_second_child[228:197], count_now[230:229], type_now[232:231],
    // zero pad [239:233]
    output logic [239:0] o_m_tdata
);

    btn_pkg::t_req                    r_req;
    btn_pkg::t_res                    r_res;
    btn_pkg::t_res                    w_res;
    btn_pkg::t_seq_ctl                w_ctl;
    btn_pkg::t_flags                  w_flags;
    logic signed [btn_pkg::KEY_W-1:0] w_slot_key;
    logic                             r_out_valid;
    logic                             w_accept;
    logic                             w_out_free;

    assign w_accept   = i_s_tvalid && w_ctl.ready;
    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.op    <= i_s_tuser;
            r_req.key   <= i_s_tdata[31:0];
            r_req.rec   <= i_s_tdata[63:32];
            r_req.chd   <= i_s_tdata[95:64];
            r_req.slot  <= i_s_tdata[97:96];
            r_req.ntype <= i_s_tdata[99:98];
        end
    end

    btn_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_out_free (w_out_free),
        .i_probe    (r_req.key),
        .i_slot_key (w_slot_key),
        .o_ctl      (w_ctl),
        .o_flags    (w_flags)
    );

    btn_node u_node (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_commit   (w_ctl.commit),
        .i_req      (r_req),
        .i_flags    (w_flags),
        .i_scan_idx (w_ctl.scan_idx),
        .o_slot_key (w_slot_key),
        .o_res      (w_res)
    );

    // The response register lets a new request start while one waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.commit) begin
            r_res <= w_res;
        end
    end

    assign o_s_tready = w_ctl.ready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_res.kind, r_res.count, r_res.rc1, r_res.rc0,
                         r_res.rr, r_res.rk, r_res.pr, r_res.pk, r_res.split,
                         r_res.routed, r_res.found, r_res.status};

endmodule

// ----- hdl/btn_checker.sv -----
// Port-level checks for the B-tree node engine, bound to the top level.
// Depends only on the top level's ports.
module btn_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [103:0] i_s_tdata,
    input logic [2:0]   i_s_tuser,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [239:0] o_m_tdata
);

    logic w_s_take;
    assign w_s_take = i_s_tvalid && o_s_tready && (i_s_tdata[0] || !i_s_tdata[0])
                      && (i_s_tuser[0] || !i_s_tuser[0]);

    // The engine works on one request at a time.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_take |=> !o_s_tready)
        else $error("request taken while previous one is still in work");

    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled response changed or dropped");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("response valid right after reset");

    a_type_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[232:231] != 2'd3)
        else $error("node type code three reported");

    // A split always leaves two keys and is never a rejection.
    a_split_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[36] |-> o_m_tdata[230:229] == 2'd2 && !o_m_tdata[0])
        else $error("split response with wrong count or status");

endmodule

bind btree_node_insert_split_engine btn_checker u_btn_checker (.*);
